// ----- hdl/bankers_safety_check_top_defines.svh -----
// Assertion macros used by the banker's safety check controller
`ifndef BANKERS_SAFETY_CHECK_TOP_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define BSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/bsc_pkg.sv -----
// Package for the banker's safety check: types, constants, codes
package bsc_pkg;
    localparam int MaxProcsDef  = 16;
    localparam int MaxResDef    = 8;
    localparam int ValueBitsDef = 16;

    localparam int ProcIdxW = 4;
    localparam int ResIdxW  = 3;
    localparam int FieldW   = 16;
    localparam int NumProcW = 5;
    localparam int NumResW  = 4;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 5;

    localparam logic [CfgIdxW-1:0] CfgNumProcs = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgNumRes   = 1'd1;

    typedef enum logic [1:0] {
        REQ_CELL  = 2'd0,
        REQ_AVAIL = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD,
        ST_CHK,
        ST_ADD,
        ST_NEXTP,
        ST_OUT_RD,
        ST_OUT,
        ST_UNSAFE,
        ST_EMPTY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_cell;
        logic load_avail;
        logic init_clear;   // clear work/done/count, begin copy
        logic init_copy;    // copy avail[res] into work[res]
        logic res_clr;      // res counter to 0
        logic res_inc;
        logic proc_clr;
        logic proc_inc;
        logic rd_cell;      // clear fail flag when res counter is 0
        logic cmp_step;     // check one resource
        logic add_step;     // add one allocation
        logic grant;        // record proc as granted
        logic pass_clr;     // clear found flag
        logic out_clr;
        logic out_inc;
        logic out_rd;
    } bsc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic res_last;     // res counter at last active resource
        logic res_none;     // no active resources
        logic proc_last;
        logic proc_done;    // current proc already granted
        logic fail;         // a resource check failed
        logic found;
        logic all_granted;
        logic out_last;
        logic no_procs;
    } bsc_sts_t;
endpackage

// ----- hdl/bsc_if.sv -----
// Valid/ready channel interface carrying a generic payload
interface bsc_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/bsc_ram.sv -----
// Generic single-port-write, single-read RAM with registered read
module bsc_ram #(
    parameter int Width = 16,
    parameter int Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/bsc_datapath.sv -----
// Datapath: stores, work vector, done flags, grant order
module bsc_datapath import bsc_pkg::*; #(
    parameter int MaxProcs  = MaxProcsDef,
    parameter int MaxRes    = MaxResDef,
    parameter int ValueBits = ValueBitsDef
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bsc_cmd_t            cmd,
    input  logic [ProcIdxW-1:0] in_proc,
    input  logic [ResIdxW-1:0]  in_res,
    input  logic [FieldW-1:0]   in_alloc,
    input  logic [FieldW-1:0]   in_max,
    input  logic [FieldW-1:0]   in_avail,
    input  logic [NumProcW-1:0] num_procs,
    input  logic [NumResW-1:0]  num_res,
    output bsc_sts_t            sts,
    output logic [ProcIdxW-1:0] out_proc
);
    localparam int PW    = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
    localparam int RW    = (MaxRes > 1) ? $clog2(MaxRes) : 1;
    localparam int CellW = $clog2(MaxProcs * MaxRes);
    localparam int CellD = 1 << CellW;
    localparam int PCW   = $clog2(MaxProcs + 1);
    localparam int RCW   = $clog2(MaxRes + 1);
    localparam int WorkW = ValueBits + $clog2(MaxProcs + 1);

    // active counts, saturated
    logic [PCW-1:0] np;
    logic [RCW-1:0] nr;
    assign np = (32'(num_procs) > MaxProcs) ? PCW'(MaxProcs) : PCW'(num_procs);
    assign nr = (32'(num_res) > MaxRes) ? RCW'(MaxRes) : RCW'(num_res);

    logic [PW-1:0]    proc_reg, proc_next;
    logic [RW-1:0]    res_reg, res_next;
    logic [PW-1:0]    outp_reg, outp_next;
    logic [PCW-1:0]   cnt_reg, cnt_next;
    logic             found_reg, found_next;
    logic             fail_reg, fail_next;
    logic [MaxProcs-1:0] done_reg, done_next;
    logic [WorkW-1:0] work_reg [MaxRes];
    logic [PW-1:0]    order_reg [MaxProcs];

    // cell stores: pack alloc and max in one word
    logic             cell_we;
    logic [CellW-1:0] cell_waddr, cell_raddr;
    logic [2*ValueBits-1:0] cell_wdata, cell_rdata;
    logic             in_ok;
    logic             av_we;
    logic [ValueBits-1:0] av_rdata;

    assign in_ok = (32'(in_proc) < MaxProcs) && (32'(in_res) < MaxRes);
    assign cell_we = cmd.load_cell && in_ok;
    assign cell_waddr = CellW'(32'(in_proc) * MaxRes + 32'(in_res));
    assign cell_wdata = {ValueBits'(in_max), ValueBits'(in_alloc)};
    // read ahead on the next counters so the registered data lines up with them
    assign cell_raddr = CellW'(32'(proc_next) * MaxRes + 32'(res_next));
    assign av_we = cmd.load_avail && (32'(in_res) < MaxRes);

    bsc_ram #(.Width(2 * ValueBits), .Depth(CellD)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    bsc_ram #(.Width(ValueBits), .Depth(1 << RW)) u_avail_ram (
        .clk   (clk),
        .we    (av_we),
        .waddr (RW'(in_res)),
        .wdata (ValueBits'(in_avail)),
        .raddr (res_reg),
        .rdata (av_rdata)
    );

    logic [ValueBits-1:0] c_alloc, c_max;
    logic                 need_gt;
    assign c_alloc = cell_rdata[ValueBits-1:0];
    assign c_max   = cell_rdata[2*ValueBits-1:ValueBits];
    // need > work, with need possibly negative
    assign need_gt = (c_max > c_alloc) &&
                     (WorkW'(c_max - c_alloc) > work_reg[res_reg]);

    always_comb
    begin
        proc_next  = proc_reg;
        res_next   = res_reg;
        outp_next  = outp_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        fail_next  = fail_reg;
        done_next  = done_reg;
        if (cmd.res_clr)  res_next = '0;
        if (cmd.res_inc)  res_next = res_reg + RW'(1);
        if (cmd.proc_clr) proc_next = '0;
        if (cmd.proc_inc) proc_next = proc_reg + PW'(1);
        if (cmd.pass_clr) found_next = 1'b0;
        if (cmd.rd_cell && 32'(res_reg) == 0) fail_next = 1'b0;
        if (cmd.cmp_step && need_gt) fail_next = 1'b1;
        if (cmd.grant)
        begin
            done_next[proc_reg] = 1'b1;
            cnt_next   = cnt_reg + PCW'(1);
            found_next = 1'b1;
        end
        if (cmd.init_clear)
        begin
            done_next = '0;
            cnt_next  = '0;
        end
        if (cmd.out_clr) outp_next = '0;
        if (cmd.out_inc) outp_next = outp_reg + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_reg  <= '0;
            res_reg   <= '0;
            outp_reg  <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            fail_reg  <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            proc_reg  <= proc_next;
            res_reg   <= res_next;
            outp_reg  <= outp_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            fail_reg  <= fail_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxRes; i++) work_reg[i] <= '0;
        end
        else if (cmd.init_clear)
        begin
            for (int i = 0; i < MaxRes; i++) work_reg[i] <= '0;
        end
        else if (cmd.init_copy)
        begin
            work_reg[res_reg] <= WorkW'(av_rdata);
        end
        else if (cmd.add_step)
        begin
            work_reg[res_reg] <= work_reg[res_reg] + WorkW'(c_alloc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grant)
        begin
            order_reg[cnt_reg[PW-1:0]] <= proc_reg;
        end
        if (cmd.out_rd)
        begin
            out_proc <= ProcIdxW'(order_reg[outp_reg]);
        end
    end

    assign sts.res_last    = (32'(res_reg) + 1 >= 32'(nr));
    assign sts.res_none    = (nr == '0);
    assign sts.proc_last   = (32'(proc_reg) + 1 >= 32'(np));
    assign sts.proc_done   = done_reg[proc_reg];
    assign sts.fail        = fail_reg;
    assign sts.found       = found_reg;
    assign sts.all_granted = (cnt_reg >= np);
    assign sts.out_last    = (32'(outp_reg) + 1 >= 32'(np));
    assign sts.no_procs    = (np == '0);
endmodule

// ----- hdl/bsc_ctrl.sv -----
// Controller state machine sequencing loads, the scan and the readout
module bsc_ctrl import bsc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  req_t     in_req,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     out_has,
    output logic     out_safe,
    output logic     out_last,
    output bsc_cmd_t cmd,
    input  bsc_sts_t sts
);
    `include "bankers_safety_check_top_defines.svh"

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // init: read avail[r] then copy it, one resource after another (read registered)
    logic init_rd_reg, init_rd_next;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_rd_reg <= 1'b0;
        end
        else
        begin
            init_rd_reg <= init_rd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        init_rd_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_req == REQ_RUN)
                begin
                    state_next = sts.no_procs ? ST_EMPTY : ST_INIT;
                end
            end
            ST_INIT:
            begin
                // read phase (init_rd_reg low), then copy phase (init_rd_reg high)
                if (sts.res_none)
                begin
                    state_next = ST_RD;
                end
                else if (!init_rd_reg)
                begin
                    init_rd_next = 1'b1;
                end
                else if (sts.res_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (sts.proc_done || sts.res_none) state_next = ST_NEXTP;
                else state_next = ST_CHK;
            end
            ST_CHK:
            begin
                state_next = sts.res_last ? ST_NEXTP : ST_CHK;
            end
            ST_NEXTP:
            begin
                if (sts.res_none && !sts.proc_done) state_next = ST_ADD;
                else if (!sts.proc_done && !sts.fail) state_next = ST_ADD;
                else if (!sts.proc_last) state_next = ST_RD;
                else if (!sts.found) state_next = ST_UNSAFE;
                else state_next = ST_RD;
            end
            ST_ADD:
            begin
                if (sts.res_none || sts.res_last)
                begin
                    if (sts.all_granted) state_next = ST_OUT_RD;
                    else state_next = ST_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            ST_UNSAFE: if (out_ready) state_next = ST_IDLE;
            ST_EMPTY:  if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ST_ADD ends once every active resource has been added; the run is
    // complete when an add ends with the grant count at the active process count
    logic add_done;
    assign add_done = sts.res_none || sts.res_last;

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        out_has   = 1'b0;
        out_safe  = 1'b0;
        out_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_cell  = in_fire && in_req == REQ_CELL;
                cmd.load_avail = in_fire && in_req == REQ_AVAIL;
                if (in_fire && in_req == REQ_RUN)
                begin
                    cmd.init_clear = 1'b1;
                    cmd.res_clr    = 1'b1;
                    cmd.proc_clr   = 1'b1;
                    cmd.pass_clr   = 1'b1;
                end
            end
            ST_INIT:
            begin
                if (init_rd_reg)
                begin
                    cmd.init_copy = !sts.res_none;
                    cmd.res_inc   = !sts.res_last;
                    cmd.res_clr   = sts.res_last;
                end
                if (sts.res_none) cmd.res_clr = 1'b1;
                if (state_next == ST_RD) cmd.rd_cell = 1'b1;
            end
            ST_RD:
            begin
                cmd.rd_cell = 1'b1;
            end
            ST_CHK:
            begin
                cmd.cmp_step = 1'b1;
                if (!sts.res_last)
                begin
                    cmd.res_inc = 1'b1;
                end
                else
                begin
                    cmd.res_clr = 1'b1;
                end
            end
            ST_NEXTP:
            begin
                if (state_next == ST_ADD)
                begin
                    cmd.grant = 1'b1;
                end
                else if (sts.proc_last)
                begin
                    cmd.proc_clr = 1'b1;
                    cmd.pass_clr = 1'b1;
                end
                else
                begin
                    cmd.proc_inc = 1'b1;
                end
            end
            ST_ADD:
            begin
                cmd.add_step = !sts.res_none;
                if (add_done)
                begin
                    cmd.res_clr = 1'b1;
                    if (sts.all_granted)
                    begin
                        cmd.proc_clr = 1'b1;
                        cmd.out_clr  = 1'b1;
                        cmd.out_rd   = 1'b1;
                    end
                    else if (sts.proc_last)
                    begin
                        cmd.proc_clr = 1'b1;
                        cmd.pass_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.proc_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.res_inc = 1'b1;
                end
            end
            ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                out_has   = 1'b1;
                out_safe  = 1'b1;
                out_last  = sts.out_last;
                cmd.out_inc = out_ready;
            end
            ST_UNSAFE:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
            end
            ST_EMPTY:
            begin
                out_valid = 1'b1;
                out_safe  = 1'b1;
                out_last  = 1'b1;
            end
            default: ;
        endcase
    end

    `BSC_ASSERT_IMP(a_no_in_when_busy, clk, rst_n, state_reg != ST_IDLE, !in_ready, "input taken while busy")
    `BSC_ASSERT_IMP(a_out_only_busy, clk, rst_n, out_valid, state_reg != ST_IDLE, "result shown while idle")
    `BSC_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_last) && $stable(out_safe), "stalled result changed")
endmodule

// ----- hdl/bankers_safety_check_top.sv -----
// Top level of the banker's algorithm safety check
//
// Use: configure num_procs (index 0) and num_res (index 1) over the write
// port while idle. Feed words on in_ch: type 0 loads one allocation/maximum
// cell, type 1 loads one available count, type 2 runs the safety check,
// type 3 is dropped. Load words are taken one per cycle while idle.
// A run copies available into work (a read, then a copy, per resource),
// then scans processes pass after pass. Each pending process is read,
// checked resource by resource, reading one cell from the cell RAM port
// per cycle, and when granted has its allocation added into work resource
// by resource; a process already granted is read and passed over. The scan
// stops at the last grant. in_ch is not ready throughout. A safe run then
// gives one word per process on out_ch, is_last on the final one; unsafe
// or empty runs give one word.
// out_ch holds its word while ready is low; the readout waits there.
// Reset clears the controller, counters, done flags and work; the stores
// are undefined until loaded.
module bankers_safety_check_top import bsc_pkg::*; #(
    parameter int MaxProcs  = MaxProcsDef,
    parameter int MaxRes    = MaxResDef,
    parameter int ValueBits = ValueBitsDef
) (
    input  logic                clk,
    input  logic                rst_n,
    bsc_if.sink                 in_ch,
    bsc_if.source               out_ch,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);
    logic [NumProcW-1:0] num_procs_reg;
    logic [NumResW-1:0]  num_res_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_procs_reg <= '0;
            num_res_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgNumProcs: num_procs_reg <= cfg_data[NumProcW-1:0];
                CfgNumRes:   num_res_reg   <= cfg_data[NumResW-1:0];
                default: ;
            endcase
        end
    end

    bsc_cmd_t cmd;
    bsc_sts_t sts;
    logic [ProcIdxW-1:0] out_proc;

    bsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_req    (req_t'(in_ch.data.req_type)),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_has   (out_ch.data.has_proc),
        .out_safe  (out_ch.data.is_safe),
        .out_last  (out_ch.data.is_last),
        .cmd       (cmd),
        .sts       (sts)
    );

    bsc_datapath #(
        .MaxProcs  (MaxProcs),
        .MaxRes    (MaxRes),
        .ValueBits (ValueBits)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_proc   (in_ch.data.proc_index),
        .in_res    (in_ch.data.res_index),
        .in_alloc  (in_ch.data.alloc_value),
        .in_max    (in_ch.data.max_value),
        .in_avail  (in_ch.data.avail_value),
        .num_procs (num_procs_reg),
        .num_res   (num_res_reg),
        .sts       (sts),
        .out_proc  (out_proc)
    );

    assign out_ch.data.granted_proc = out_ch.data.has_proc ? out_proc : '0;
endmodule
